// File: hw/rtl/rgb_to_hsl_converter_macros.svh
// assertion macros used by the rtl
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication
`define RGBHSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsl_converter: same-cycle check failed");

// next-cycle implication
`define RGBHSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hsl_converter: next-cycle check failed");

`endif

// File: hw/rtl/rgbhsl_pkg.sv
package rgbhsl_pkg;

   localparam int CHAN_W    = 8;
   localparam int FRAC_W    = 16;
   localparam int HUE_DIV_W = 11;
   localparam int SAT_DIV_W = 9;
   localparam int SAT_NUM_W = 25;
   localparam int LIGHT_W   = 17;

   typedef enum logic [1:0] {
      CHAN_RED,
      CHAN_GREEN,
      CHAN_BLUE
   } max_chan_type;

endpackage

// File: hw/rtl/rgbhsl_div.sv
module rgbhsl_div #(
   parameter int DIV_W          = 11,
   parameter int BITS_PER_STAGE = 2
) (
   input  logic                             clock,
   input  logic                             enable,
   input  logic [DIV_W-1:0]                 num_hi,
   input  logic [rgbhsl_pkg::FRAC_W-1:0]    num_lo,
   input  logic [DIV_W-1:0]                 divisor,
   output logic [rgbhsl_pkg::FRAC_W-1:0]    quotient
);

   localparam int FW     = rgbhsl_pkg::FRAC_W;
   localparam int STAGES = FW / BITS_PER_STAGE;

   // word holds the numerator bits still to come and shifts quotient bits in
   logic [DIV_W-1:0] rem_ff  [STAGES];
   logic [DIV_W-1:0] rem_in  [STAGES];
   logic [FW-1:0]    word_ff [STAGES];
   logic [FW-1:0]    word_in [STAGES];
   logic [DIV_W-1:0] div_ff  [STAGES];
   logic [DIV_W-1:0] src_rem [STAGES];
   logic [FW-1:0]    src_word[STAGES];
   logic [DIV_W-1:0] src_div [STAGES];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      if (i == 0) begin : g_first
         assign src_rem[i]  = num_hi;
         assign src_word[i] = num_lo;
         assign src_div[i]  = divisor;
      end else begin : g_rest
         assign src_rem[i]  = rem_ff[i-1];
         assign src_word[i] = word_ff[i-1];
         assign src_div[i]  = div_ff[i-1];
      end

      always_comb begin
         logic [DIV_W-1:0] rem;
         logic [FW-1:0]    word;
         logic [DIV_W:0]   trial;
         rem  = src_rem[i];
         word = src_word[i];
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial = {rem, word[FW-1]};
            if (trial >= {1'b0, src_div[i]}) begin
               rem  = DIV_W'(trial - {1'b0, src_div[i]});
               word = {word[FW-2:0], 1'b1};
            end else begin
               rem  = trial[DIV_W-1:0];
               word = {word[FW-2:0], 1'b0};
            end
         end
         rem_in[i]  = rem;
         word_in[i] = word;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in[i];
            word_ff[i] <= word_in[i];
            div_ff[i]  <= src_div[i];
         end
      end
   end

   assign quotient = word_ff[STAGES-1];

endmodule

// File: hw/rtl/rgb_to_hsl_converter.sv
// channel | ports                                   | dir | beat
// req     | req_valid req_ready req_red/green/blue  | in  | one 8-bit rgb pixel
// rsp     | rsp_valid rsp_ready rsp_hue/saturation/ | out | 16-bit hue, saturation,
//         | rsp_lightness                           |     | lightness
//
// one pixel accepted every clock while rsp is not stalled; the path runs through stage a,
// stage b and the stages of the two pipelined restoring dividers
// reset clears the valid bits only, no clearing pass
// a stalled rsp freezes every stage; req_ready = !rsp_valid || rsp_ready
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter #(
   parameter int BITS_PER_STAGE = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_hue,
   output logic [15:0] rsp_saturation,
   output logic [15:0] rsp_lightness
);

   localparam int CW     = rgbhsl_pkg::CHAN_W;
   localparam int FW     = rgbhsl_pkg::FRAC_W;
   localparam int HW     = rgbhsl_pkg::HUE_DIV_W;
   localparam int SW     = rgbhsl_pkg::SAT_DIV_W;
   localparam int NW     = rgbhsl_pkg::SAT_NUM_W;
   localparam int LW     = rgbhsl_pkg::LIGHT_W;
   localparam int STAGES = FW / BITS_PER_STAGE;

   logic pipe_en;
   logic [STAGES+1:0] valid_ff;

   // stage a: max, min and which channel wins
   logic [CW-1:0] red_ff, green_ff, blue_ff, max_ff, min_ff;
   logic [CW-1:0] max_in, min_in;
   rgbhsl_pkg::max_chan_type top_ff, top_in;

   // stage b: divider operands
   logic [CW-1:0] d_b, den_b;
   logic [CW:0]   s_b;
   logic [HW-1:0] six_b, n_b;
   logic [NW-1:0] sat_num_b;
   logic [LW-1:0] light_sum_b;
   logic          gray_b;

   logic [HW-1:0] hue_hi_ff, hue_div_ff;
   logic [SW-1:0] sat_hi_ff, sat_div_ff;
   logic [FW-1:0] sat_lo_ff;
   logic [FW-1:0] light_b_ff;
   logic [FW-1:0] light_ff [STAGES];

   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = valid_ff[STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[STAGES:0], req_valid};
      end
   end

   always_comb begin
      if (req_red >= req_green && req_red >= req_blue) begin
         top_in = rgbhsl_pkg::CHAN_RED;
         max_in = req_red;
      end else if (req_green >= req_blue) begin
         top_in = rgbhsl_pkg::CHAN_GREEN;
         max_in = req_green;
      end else begin
         top_in = rgbhsl_pkg::CHAN_BLUE;
         max_in = req_blue;
      end
      if (req_red <= req_green && req_red <= req_blue) begin
         min_in = req_red;
      end else if (req_green <= req_blue) begin
         min_in = req_green;
      end else begin
         min_in = req_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         max_ff   <= max_in;
         min_ff   <= min_in;
         top_ff   <= top_in;
      end
   end

   always_comb begin
      d_b    = max_ff - min_ff;
      s_b    = {1'b0, max_ff} + {1'b0, min_ff};
      gray_b = (d_b == '0);
      six_b  = HW'({d_b, 2'b00}) + HW'({d_b, 1'b0});
      case (top_ff)
         rgbhsl_pkg::CHAN_RED: begin
            if (green_ff >= blue_ff) begin
               n_b = HW'(green_ff - blue_ff);
            end else begin
               n_b = six_b - HW'(blue_ff - green_ff);
            end
         end
         rgbhsl_pkg::CHAN_GREEN: n_b = HW'({d_b, 1'b0}) + HW'(blue_ff) - HW'(red_ff);
         default:                n_b = HW'({d_b, 2'b00}) + HW'(red_ff) - HW'(green_ff);
      endcase
      // below one half divide by max+min, otherwise by 2-max-min
      if (s_b < (CW+1)'(255)) begin
         den_b = s_b[CW-1:0];
      end else begin
         den_b = CW'((CW+1)'(510) - s_b);
      end
      // 2*d*65535 + den, the +den rounds to nearest
      sat_num_b   = (NW'(d_b) << 17) - (NW'(d_b) << 1) + NW'(den_b);
      light_sum_b = LW'({s_b, 8'b0}) + LW'(s_b) + LW'(1);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         light_b_ff <= light_sum_b[LW-1:1];
         if (gray_b) begin
            hue_hi_ff  <= '0;
            hue_div_ff <= HW'(1);
            sat_hi_ff  <= '0;
            sat_lo_ff  <= '0;
            sat_div_ff <= SW'(1);
         end else begin
            hue_hi_ff  <= n_b;
            hue_div_ff <= six_b;
            sat_hi_ff  <= sat_num_b[NW-1:FW];
            sat_lo_ff  <= sat_num_b[FW-1:0];
            sat_div_ff <= {den_b, 1'b0};
         end
      end
   end

   rgbhsl_div #(
      .DIV_W         (HW),
      .BITS_PER_STAGE(BITS_PER_STAGE)
   ) u_hue_div (
      .clock   (clock),
      .enable  (pipe_en),
      .num_hi  (hue_hi_ff),
      .num_lo  ('0),
      .divisor (hue_div_ff),
      .quotient(rsp_hue)
   );

   rgbhsl_div #(
      .DIV_W         (SW),
      .BITS_PER_STAGE(BITS_PER_STAGE)
   ) u_sat_div (
      .clock   (clock),
      .enable  (pipe_en),
      .num_hi  (sat_hi_ff),
      .num_lo  (sat_lo_ff),
      .divisor (sat_div_ff),
      .quotient(rsp_saturation)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         light_ff[0] <= light_b_ff;
         for (int i = 1; i < STAGES; i++) begin
            light_ff[i] <= light_ff[i-1];
         end
      end
   end

   assign rsp_lightness = light_ff[STAGES-1];

   // wrapped hue numerator stays below 6*d
   `RGBHSL_ASSERT_NOW(a_hue_wrap, clock, reset, valid_ff[0] && !gray_b, n_b < six_b)
   // black and white pixels are gray
   `RGBHSL_ASSERT_NOW(a_sat_extreme, clock, reset,
      rsp_valid && (rsp_lightness == '0 || rsp_lightness == '1), rsp_saturation == '0)
   // a stall freezes every valid bit
   `RGBHSL_ASSERT_NEXT(a_stall_hold, clock, reset, !pipe_en, $stable(valid_ff))
   // nothing enters while stalled
   `RGBHSL_ASSERT_NEXT(a_no_entry, clock, reset, !pipe_en, $stable(valid_ff[0]))

endmodule

// File: test/rgb_to_hsl_checker.sv
`timescale 1ns / 100ps

module rgb_to_hsl_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_hue,
   input  logic [15:0] rsp_saturation,
   input  logic [15:0] rsp_lightness,
   output int          mismatch_count,
   output int          pixels_in_flight
);

   typedef struct packed {
      logic [15:0] hue;
      logic [15:0] saturation;
      logic [15:0] lightness;
   } hsl_value_type;

   typedef struct packed {
      logic [23:0]   pixel;
      hsl_value_type hsl;
   } hsl_expected_type;

   hsl_expected_type hsl_pending[$];

   function automatic hsl_value_type hsl_of_pixel(logic [7:0] red, logic [7:0] green,
                                                  logic [7:0] blue);
      int                       brightest;
      int                       darkest;
      int                       spread;
      int                       total;
      int                       divisor;
      int                       offset;
      rgbhsl_pkg::max_chan_type peak;
      hsl_value_type            hsl;
      brightest = red;
      if (green > brightest) brightest = green;
      if (blue > brightest) brightest = blue;
      darkest = red;
      if (green < darkest) darkest = green;
      if (blue < darkest) darkest = blue;
      spread = brightest - darkest;
      total = brightest + darkest;
      hsl.lightness = 16'((total * 257 + 1) / 2);
      hsl.hue = '0;
      hsl.saturation = '0;
      if (spread != 0) begin
         divisor = (total < 255) ? total : 510 - total;
         hsl.saturation = 16'((2 * spread * 65535 + divisor) / (2 * divisor));
         // ties go to red, then green
         if (int'(red) == brightest) peak = rgbhsl_pkg::CHAN_RED;
         else if (int'(green) == brightest) peak = rgbhsl_pkg::CHAN_GREEN;
         else peak = rgbhsl_pkg::CHAN_BLUE;
         case (peak)
            rgbhsl_pkg::CHAN_RED:   offset = int'(green) - int'(blue);
            rgbhsl_pkg::CHAN_GREEN: offset = 2 * spread + int'(blue) - int'(red);
            default:                offset = 4 * spread + int'(red) - int'(green);
         endcase
         if (offset < 0) offset += 6 * spread;
         hsl.hue = 16'((offset * 65536) / (6 * spread));
      end
      return hsl;
   endfunction

   task automatic compare_field(string name, logic [23:0] pixel, logic [15:0] want,
                                logic [15:0] seen);
      if (want !== seen) begin
         if (mismatch_count < 10)
            $display("%s mismatch for rgb %h: expected %h, got %h", name, pixel, want, seen);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      hsl_expected_type oldest;
      if (reset) begin
         hsl_pending.delete();
         mismatch_count = 0;
         pixels_in_flight = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hsl_pending.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result beat: hue %h saturation %h lightness %h",
                           rsp_hue, rsp_saturation, rsp_lightness);
               mismatch_count++;
            end else begin
               oldest = hsl_pending.pop_front();
               compare_field("hue", oldest.pixel, oldest.hsl.hue, rsp_hue);
               compare_field("saturation", oldest.pixel, oldest.hsl.saturation,
                             rsp_saturation);
               compare_field("lightness", oldest.pixel, oldest.hsl.lightness,
                             rsp_lightness);
            end
         end
         if (req_valid && req_ready)
            hsl_pending.push_back('{pixel: {req_red, req_green, req_blue},
                                    hsl: hsl_of_pixel(req_red, req_green, req_blue)});
         pixels_in_flight = hsl_pending.size();
      end
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_PIXELS = 1300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [15:0] rsp_hue;
   logic [15:0] rsp_saturation;
   logic [15:0] rsp_lightness;
   int          mismatch_count;
   int          pixels_in_flight;
   int          pixels_sent = 0;
   int          cycle_count = 0;

   always #5 clock = ~clock;

   rgb_to_hsl_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   rgb_to_hsl_checker hsl_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hue          (rsp_hue),
      .rsp_saturation   (rsp_saturation),
      .rsp_lightness    (rsp_lightness),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] corner_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd127;
         3: return 8'd128;
         4: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   task automatic offer_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input bit steady);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
   endtask

   initial begin
      int         roll;
      bit         steady;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // corners, ties, the s = 255 boundary and wrapped hue
      offer_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      offer_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      offer_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      offer_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      offer_pixel(8'd0, 8'd0, 8'd255, 1'b1);
      offer_pixel(8'd255, 8'd255, 8'd0, 1'b1);
      offer_pixel(8'd0, 8'd255, 8'd255, 1'b0);
      offer_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      offer_pixel(8'd128, 8'd128, 8'd128, 1'b0);
      offer_pixel(8'd1, 8'd0, 8'd0, 1'b1);
      offer_pixel(8'd0, 8'd1, 8'd0, 1'b1);
      offer_pixel(8'd0, 8'd0, 8'd1, 1'b0);
      offer_pixel(8'd254, 8'd255, 8'd255, 1'b0);
      offer_pixel(8'd255, 8'd0, 8'd1, 1'b0);
      offer_pixel(8'd255, 8'd1, 8'd0, 1'b0);
      offer_pixel(8'd128, 8'd127, 8'd127, 1'b1);
      offer_pixel(8'd127, 8'd126, 8'd126, 1'b0);
      offer_pixel(8'd127, 8'd128, 8'd127, 1'b0);
      offer_pixel(8'd200, 8'd100, 8'd50, 1'b0);
      offer_pixel(8'd50, 8'd200, 8'd100, 1'b1);
      offer_pixel(8'd100, 8'd50, 8'd200, 1'b0);
      offer_pixel(8'd1, 8'd1, 8'd0, 1'b0);
      offer_pixel(8'd0, 8'd1, 8'd1, 1'b0);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         roll   = $urandom_range(0, 99);
         steady = (i % 200) < 60;
         red    = 8'($urandom);
         green  = 8'($urandom);
         blue   = 8'($urandom);
         if (roll < 15) begin
            green = red;
            blue  = red;
         end else if (roll < 30) begin
            case ($urandom_range(0, 2))
               0: green = red;
               1: blue = green;
               default: red = blue;
            endcase
         end else if (roll < 40) begin
            blue = red - 8'd1;
         end else if (roll < 50) begin
            red   = corner_level();
            green = corner_level();
            blue  = corner_level();
         end
         offer_pixel(red, green, blue, steady);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pixels_in_flight == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side: random stalls plus two long hold-offs while the source keeps offering pixels
   initial begin
      int run;
      int stall;
      int holds_done;
      holds_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < 2 && pixels_sent >= 300 + 600 * holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            repeat (run) @(posedge clock);
            stall = idle_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: rgb_to_hsl_converter.f
+incdir+hw/rtl
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgbhsl_div.sv
hw/rtl/rgb_to_hsl_converter.sv
test/rgb_to_hsl_checker.sv
test/testbench.sv
